FILE: design/sorted_set_insert_remove_assert.svh
// Assertion macros for the sorted set block.
`ifndef SORTED_SET_INSERT_REMOVE_ASSERT_SVH
`define SORTED_SET_INSERT_REMOVE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SSIR_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("sorted set: invariant violated");

// When ante holds, cons must hold in the next cycle.
`define SSIR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sorted set: next-cycle check failed");

`endif

FILE: design/ssir_pkg.sv
`timescale 1ns / 1ps
package ssir_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                    cmp_en;
        logic                    ins_en;
        logic                    rem_en;
        logic                    descending;
        logic signed [VAL_W-1:0] value;
    } cell_ctl_t;

endpackage

FILE: design/ssir_cell.sv
`timescale 1ns / 1ps
module ssir_cell (
    input  logic                              aclk,
    input  ssir_pkg::cell_ctl_t               ctl,
    input  logic                              occupied,
    input  logic signed [ssir_pkg::VAL_W-1:0] left_entry,
    input  logic signed [ssir_pkg::VAL_W-1:0] right_entry,
    input  logic                              stop_in,
    input  logic                              found_in,
    output logic signed [ssir_pkg::VAL_W-1:0] entry,
    output logic                              stop_out,
    output logic                              found_out
);

    logic signed [ssir_pkg::VAL_W-1:0] entry_reg;
    logic                              prec_reg;
    logic                              eq_reg;
    logic                              first;

    // first: this cell is the search position (first entry not preceding value)
    assign first     = !stop_in && !prec_reg;
    assign stop_out  = stop_in || !prec_reg;
    assign found_out = found_in || (first && eq_reg);
    assign entry     = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            prec_reg <= occupied && (ctl.descending ? (entry_reg > ctl.value)
                                                    : (entry_reg < ctl.value));
            eq_reg   <= occupied && (entry_reg == ctl.value);
        end
        if (ctl.ins_en) begin
            if (first) begin
                entry_reg <= ctl.value;
            end else if (stop_in) begin
                entry_reg <= left_entry;
            end
        end else if (ctl.rem_en && (first || stop_in)) begin
            entry_reg <= right_entry;
        end
    end

endmodule

FILE: design/sorted_set_insert_remove.sv
`timescale 1ns / 1ps
// Channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// s_       | s_valid s_ready s_opcode s_value        | in
// m_       | m_valid m_ready m_status m_entry_count  | out
// cfg_     | cfg_we cfg_wdata (order_descending)     | in
//
// Each item is accepted, compared in all cells, then committed with the shift.
// The search position ripples through the row of cells in the commit cycle.
// Reset (aresetn, synchronous) empties the set and selects ascending order.
// A result waiting in the output register holds the current item in the
// commit step; s_ready stays low until that item commits.
module sorted_set_insert_remove (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic signed [ssir_pkg::VAL_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic [ssir_pkg::CNT_W-1:0]        m_entry_count,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata
);

`include "sorted_set_insert_remove_assert.svh"

    localparam int N = ssir_pkg::CAPACITY;
    localparam int W = ssir_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_COMMIT
    } state_t;

    state_t                            state_reg;
    logic                              desc_reg;
    logic                              op_reg;
    logic signed [ssir_pkg::VAL_W-1:0] value_reg;
    logic [W-1:0]                      count_reg;
    logic [W-1:0]                      count_next;
    logic                              m_valid_reg;
    logic [1:0]                        status_reg;
    logic [1:0]                        status_next;
    logic [W-1:0]                      m_count_reg;

    ssir_pkg::cell_ctl_t               ctl;
    logic                              commit_go;
    logic                              found;
    logic                              full;

    // Chain signals between neighboring cells
    logic signed [ssir_pkg::VAL_W-1:0] entry [N];
    logic [N:0]                        stop_chain;
    logic [N:0]                        found_chain;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_count = m_count_reg;

    // Commit only once the output register is free (or being drained now)
    assign commit_go = (state_reg == S_COMMIT) && (!m_valid_reg || m_ready);
    assign found     = found_chain[N];
    assign full      = (count_reg >= W'(N));

    assign ctl.cmp_en     = (state_reg == S_CMP);
    assign ctl.ins_en     = commit_go && (op_reg == ssir_pkg::OP_INSERT) && !found && !full;
    assign ctl.rem_en     = commit_go && (op_reg == ssir_pkg::OP_REMOVE) && found;
    assign ctl.descending = desc_reg;
    assign ctl.value      = value_reg;

    assign stop_chain[0]  = 1'b0;
    assign found_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            // Ends of the row: the value stands in for a missing neighbor,
            // it is never kept as an entry of the set (see the cell's select terms).
            logic signed [ssir_pkg::VAL_W-1:0] left_w;
            logic signed [ssir_pkg::VAL_W-1:0] right_w;
            if (gi == 0) begin : g_l0
                assign left_w = value_reg;
            end else begin : g_ln
                assign left_w = entry[gi-1];
            end
            if (gi == N - 1) begin : g_rl
                assign right_w = value_reg;
            end else begin : g_rn
                assign right_w = entry[gi+1];
            end

            ssir_cell u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .occupied    (W'(gi) < count_reg),
                .left_entry  (left_w),
                .right_entry (right_w),
                .stop_in     (stop_chain[gi]),
                .found_in    (found_chain[gi]),
                .entry       (entry[gi]),
                .stop_out    (stop_chain[gi+1]),
                .found_out   (found_chain[gi+1])
            );
        end
    endgenerate

    // Status and new count of the item in the commit cycle
    always_comb begin
        count_next  = count_reg;
        status_next = ssir_pkg::ST_DONE;
        if (op_reg == ssir_pkg::OP_INSERT) begin
            if (found) begin
                status_next = ssir_pkg::ST_REFUSED;
            end else if (full) begin
                status_next = ssir_pkg::ST_FULL;
            end else begin
                count_next = count_reg + W'(1);
            end
        end else begin
            if (!found) begin
                status_next = ssir_pkg::ST_REFUSED;
            end else begin
                count_next = count_reg - W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            desc_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= ssir_pkg::ST_DONE;
            m_count_reg <= '0;
        end else begin
            if (cfg_we) begin
                desc_reg <= cfg_wdata;
            end
            // A new result replaces one drained in the same cycle
            if (commit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (commit_go) begin
                        state_reg   <= S_IDLE;
                        count_reg   <= count_next;
                        status_reg  <= status_next;
                        m_count_reg <= count_next;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_opcode;
            value_reg <= s_value;
        end
    end

    `SSIR_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= W'(N))
    `SSIR_ASSERT_ALWAYS(a_no_status3, aclk, aresetn, !m_valid_reg || (status_reg != 2'd3))
    `SSIR_ASSERT_ALWAYS(a_full_count, aclk, aresetn,
        !m_valid_reg || (status_reg != ssir_pkg::ST_FULL) || (m_count_reg == W'(N)))
    `SSIR_ASSERT_NEXT(a_ins_grows, aclk, aresetn, ctl.ins_en, count_reg == $past(count_reg) + W'(1))
    `SSIR_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule
